### hdl/mbrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrd_pkg
// shared constants and types of the read-response deframer
// ----------------------------------------------------------------------------
package mbrd_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HR  = 8'h03;
    localparam int unsigned POS_W         = 9;
    localparam logic [POS_W-1:0] POS_MAX  = 9'd511;
    localparam logic [9:0]  MIN_LEN       = 10'd5;
    localparam logic [9:0]  HDR_CRC_LEN   = 10'd5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_ADDR  = 3'd2,
        ST_BAD_FUNC  = 3'd3,
        ST_BAD_CRC   = 3'd4,
        ST_BAD_COUNT = 3'd5
    } status_t;

endpackage

### hdl/mbrd_crc16_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrd_crc16_byte
// one byte step of the reflected crc-16 (poly 0xa001)
// ----------------------------------------------------------------------------
module mbrd_crc16_byte
    import mbrd_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

### hdl/modbus_read_response_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_read_response_deframer
// parses a read-holding-registers response byte stream into words and a verdict
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one frame byte per word, s_tlast on the final byte
//   m_ channel carries either a data word (m_tlast low) with its index, or the
//   frame verdict (m_tlast high) with the status code and zero value/index
//   data words are only sent while address and function match; the receiver
//   drops them unless the following verdict is ok
//   cfg_we / cfg_wdata load the expected station address (reset value 1);
//   write it only between frames
// timing
//   one byte per cycle sustained while m_tready stays high; a byte sits in the
//   input register after its accepting edge and its result is loaded into the
//   output register when the pipeline advances, which raises m_tvalid
//   the crc byte step and the frame checks sit between those two registers
// reset and stall
//   aresetn low clears both stages and all frame state
//   when m_tready is low with a result waiting, the pipeline holds and
//   s_tready drops once the input register is also occupied; nothing is lost
// ----------------------------------------------------------------------------
module modbus_read_response_deframer
    import mbrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // station_address
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] rx_byte
    input  logic        s_tlast,        // frame_end
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,        // [15:0] reg_value, [22:16] reg_index,
                                        // [25:23] status, [31:26] zero
    output logic        m_tlast         // last (verdict word)
);

    // configuration register
    logic [7:0] station_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // frame state
    logic [15:0]      crc_reg,      crc_next;
    logic [15:0]      trail_reg,    trail_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       count_reg,    count_next;
    logic             addr_ok_reg,  addr_ok_next;
    logic             func_ok_reg,  func_ok_next;
    logic [7:0]       high_reg,     high_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_value_reg, out_value_next;
    logic [6:0]  out_index_reg, out_index_next;
    status_t     out_status_reg, out_status_next;
    logic        out_last_reg,  out_last_next;

    logic        advance;
    logic        step;
    logic [15:0] crc_stepped;
    logic [9:0]  len;
    logic [9:0]  word_end;
    logic [8:0]  word_off;
    logic [15:0] received;
    status_t     verdict;

    // pipeline moves when the output slot is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // crc runs two bytes behind so the trailing crc bytes never enter it
    mbrd_crc16_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (trail_reg[15:8]),
        .crc_out (crc_stepped)
    );

    assign len      = {1'b0, pos_reg} + 10'd1;
    assign word_end = {2'b00, count_reg} + 10'd2;
    assign word_off = pos_reg - 9'd3;
    assign received = {in_byte_reg, trail_reg[7:0]};

    // verdict in priority order; the crc includes the byte folded in this step
    always_comb begin
        priority if (len < MIN_LEN) begin
            verdict = ST_SHORT;
        end else if (!addr_ok_reg) begin
            verdict = ST_BAD_ADDR;
        end else if (!func_ok_reg) begin
            verdict = ST_BAD_FUNC;
        end else if (received != crc_stepped) begin
            verdict = ST_BAD_CRC;
        end else if (count_reg[0] || (len != ({2'b00, count_reg} + HDR_CRC_LEN))) begin
            verdict = ST_BAD_COUNT;
        end else begin
            verdict = ST_OK;
        end
    end

    always_comb begin
        crc_next        = crc_reg;
        trail_next      = trail_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        addr_ok_next    = addr_ok_reg;
        func_ok_next    = func_ok_reg;
        high_next       = high_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        if (step) begin
            if (pos_reg >= 9'd2) begin
                crc_next = crc_stepped;
            end
            trail_next = {trail_reg[7:0], in_byte_reg};

            // header fields
            unique case (pos_reg)
                9'd0:    addr_ok_next = (in_byte_reg == station_reg);
                9'd1:    func_ok_next = (in_byte_reg == FUNC_READ_HR);
                9'd2:    count_next   = in_byte_reg;
                default: ;
            endcase

            if (in_last_reg) begin
                // verdict word, then back to an empty frame
                out_valid_next  = 1'b1;
                out_value_next  = 16'h0000;
                out_index_next  = 7'd0;
                out_status_next = verdict;
                out_last_next   = 1'b1;
                crc_next        = CRC_INIT;
                trail_next      = 16'h0000;
                pos_next        = '0;
                count_next      = 8'h00;
                addr_ok_next    = 1'b0;
                func_ok_next    = 1'b0;
                high_next       = 8'h00;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_next = pos_reg + 9'd1;
                end
                // data area: even offset holds the high byte, odd completes a word
                if ((pos_reg >= 9'd3) && ({1'b0, pos_reg} <= word_end)) begin
                    if (!word_off[0]) begin
                        high_next = in_byte_reg;
                    end else if (addr_ok_reg && func_ok_reg) begin
                        out_valid_next  = 1'b1;
                        out_value_next  = {high_reg, in_byte_reg};
                        out_index_next  = word_off[7:1];
                        out_status_next = ST_OK;
                        out_last_next   = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg   <= 8'd1;
            in_valid_reg  <= 1'b0;
            crc_reg       <= CRC_INIT;
            trail_reg     <= 16'h0000;
            pos_reg       <= '0;
            count_reg     <= 8'h00;
            addr_ok_reg   <= 1'b0;
            func_ok_reg   <= 1'b0;
            high_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                station_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            crc_reg       <= crc_next;
            trail_reg     <= trail_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            addr_ok_reg   <= addr_ok_next;
            func_ok_reg   <= func_ok_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        out_value_reg  <= out_value_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_status_reg, out_index_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule
